// File: rtl/core/pss_pkg.sv
package pss_pkg;

  // Field widths fixed by the item format
  localparam int IDX_W     = 12;
  localparam int TIME_IN_W = 24;
  localparam int SLIDE_W   = 16;
  localparam int COUNT_W   = 13;
  localparam int LOOP_W    = 24;
  localparam int STAMP_W   = 26;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  // Operation codes
  localparam logic [1:0] OP_LOAD_OFFSET  = 2'd0;
  localparam logic [1:0] OP_LOAD_PATTERN = 2'd1;
  localparam logic [1:0] OP_EVAL         = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMITTER_LIFE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INFINITE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLIDE_STEP    = 2'd3;

  // Control travelling alongside each item
  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
  } ctl_t;

endpackage

// File: rtl/core/pss_mod_pipe.sv
// Pipelined restoring remainder: one dividend bit per stage.
module pss_mod_pipe #(
  parameter int XW = 33,
  parameter int MW = 13,
  parameter int PW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_vld,
  input  pss_pkg::ctl_t    in_ctl,
  input  logic [XW-1:0]    in_x,
  input  logic [PW-1:0]    in_pay,
  input  logic [MW-1:0]    modulus,
  output logic             out_vld,
  output pss_pkg::ctl_t    out_ctl,
  output logic [MW-1:0]    out_rem,
  output logic [PW-1:0]    out_pay
);

  logic          v [0:XW];
  pss_pkg::ctl_t c [0:XW];
  logic [XW-1:0] x [0:XW];
  logic [MW-1:0] r [0:XW];
  logic [PW-1:0] p [0:XW];

  assign v[0] = in_vld;
  assign c[0] = in_ctl;
  assign x[0] = in_x;
  assign r[0] = '0;
  assign p[0] = in_pay;

  for (genvar s = 0; s < XW; s++) begin : g_stage
    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        ge;

    // shift in the next dividend bit and subtract where it fits
    assign trial = {r[s], x[s][XW-1-s]};
    assign ge    = trial >= {1'b0, modulus};
    assign diff  = trial - {1'b0, modulus};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c[s+1] <= c[s];
        x[s+1] <= x[s];
        p[s+1] <= p[s];
        r[s+1] <= ge ? diff[MW-1:0] : trial[MW-1:0];
      end
    end
  end

  assign out_vld = v[XW];
  assign out_ctl = c[XW];
  assign out_rem = r[XW];
  assign out_pay = p[XW];

endmodule

// File: rtl/core/pss_div_pipe.sv
// Two pipelined restoring dividers sharing one divisor, one bit per stage.
module pss_div_pipe #(
  parameter int T  = 24,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  pss_pkg::ctl_t in_ctl,
  input  logic [T-1:0]  num_a,
  input  logic [T-1:0]  num_b,
  input  logic [T-1:0]  den,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output pss_pkg::ctl_t out_ctl,
  output logic [T-1:0]  quo_a,
  output logic [T-1:0]  rem_a,
  output logic [T-1:0]  rem_b,
  output logic [PW-1:0] out_pay
);

  logic          v  [0:T];
  pss_pkg::ctl_t c  [0:T];
  logic [T-1:0]  na [0:T];
  logic [T-1:0]  nb [0:T];
  logic [T-1:0]  d  [0:T];
  logic [T-1:0]  q  [0:T];
  logic [T-1:0]  ra [0:T];
  logic [T-1:0]  rb [0:T];
  logic [PW-1:0] p  [0:T];

  assign v[0]  = in_vld;
  assign c[0]  = in_ctl;
  assign na[0] = num_a;
  assign nb[0] = num_b;
  assign d[0]  = den;
  assign q[0]  = '0;
  assign ra[0] = '0;
  assign rb[0] = '0;
  assign p[0]  = in_pay;

  for (genvar s = 0; s < T; s++) begin : g_stage
    logic [T:0] ta;
    logic [T:0] tb;
    logic [T:0] da;
    logic [T:0] db;
    logic       ga;
    logic       gb;

    assign ta = {ra[s], na[s][T-1-s]};
    assign tb = {rb[s], nb[s][T-1-s]};
    assign ga = ta >= {1'b0, d[s]};
    assign gb = tb >= {1'b0, d[s]};
    assign da = ta - {1'b0, d[s]};
    assign db = tb - {1'b0, d[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c[s+1]  <= c[s];
        na[s+1] <= na[s];
        nb[s+1] <= nb[s];
        d[s+1]  <= d[s];
        p[s+1]  <= p[s];
        q[s+1]  <= {q[s][T-2:0], ga};
        ra[s+1] <= ga ? da[T-1:0] : ta[T-1:0];
        rb[s+1] <= gb ? db[T-1:0] : tb[T-1:0];
      end
    end
  end

  assign out_vld = v[T];
  assign out_ctl = c[T];
  assign quo_a   = q[T];
  assign rem_a   = ra[T];
  assign rem_b   = rb[T];
  assign out_pay = p[T];

endmodule

// File: rtl/core/particle_slot_schedule.sv
// Particle slot timing scheduler.
// Input channel (in_valid / in_stall) carries load and evaluate items; op
// selects an offset load, a pattern load or a slot evaluation. Loads give
// no result. An evaluate of a slot inside the offset table gives one result
// on the output channel (out_valid / out_stall); other items are dropped.
// Configuration goes through cfg_write / cfg_index / cfg_data, one register
// per write. The user must change it only while no item is in flight; the
// block does not enforce this. Throughput: one item per cycle while the
// output is not stalled. An item passes stage A, stage B, the pattern
// selection remainder (one bit of a 33-bit sum per stage), stage C, the
// timing divider (one bit of TIME_BITS per stage) and the output register.
// The offset table is read at input; the pattern table is written and read
// at one pipeline stage, so loads and evaluates keep their order.
// Reset clears the pipeline and sets the registers to their reset values;
// table contents stay undefined until loaded.
// When the receiver stalls with a result held, the whole pipeline holds and
// in_stall rises in the same cycle.
module particle_slot_schedule #(
  parameter int SLOT_DEPTH    = 1024,
  parameter int PATTERN_DEPTH = 4096,
  parameter int TIME_BITS     = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic [pss_pkg::IDX_W-1:0]           entry_index,
  input  logic [pss_pkg::TIME_IN_W-1:0]       offset_value,
  input  logic [pss_pkg::TIME_IN_W-1:0]       pattern_cycle,
  input  logic [pss_pkg::TIME_IN_W-1:0]       pattern_life,
  input  logic [pss_pkg::TIME_IN_W-1:0]       frame_time,
  input  logic [pss_pkg::SLIDE_W-1:0]         slide,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pss_pkg::IDX_W-1:0]           slot_number,
  output logic [pss_pkg::LOOP_W-1:0]          loop_count,
  output logic [pss_pkg::STAMP_W-1:0]         start_time,
  output logic [pss_pkg::STAMP_W-1:0]         end_time,
  output logic                                exists,
  output logic                                born,
  input  logic                                cfg_write,
  input  logic [pss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pss_pkg::CFG_W-1:0]           cfg_data
);

  localparam int T   = TIME_BITS;
  localparam int SAW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int MW  = $clog2(PATTERN_DEPTH + 1);
  localparam int PRW = 2 * pss_pkg::SLIDE_W;
  localparam int XW  = PRW + 1;
  localparam int PW1 = 5 * T + 2;
  localparam int PW2 = 2 * T + 3;
  localparam int LW  = (pss_pkg::LOOP_W > T) ? pss_pkg::LOOP_W : T;

  // Configuration registers
  logic [pss_pkg::TIME_IN_W-1:0] emitter_life;
  logic                          infinite_mode;
  logic [pss_pkg::COUNT_W-1:0]   pattern_count;
  logic [pss_pkg::SLIDE_W-1:0]   slide_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      emitter_life  <= '0;
      infinite_mode <= 1'b0;
      pattern_count <= pss_pkg::COUNT_W'(1);
      slide_step    <= pss_pkg::SLIDE_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        pss_pkg::REG_EMITTER_LIFE:  emitter_life  <= cfg_data;
        pss_pkg::REG_INFINITE_MODE: infinite_mode <= cfg_data[0];
        pss_pkg::REG_PATTERN_COUNT: pattern_count <= cfg_data[pss_pkg::COUNT_W-1:0];
        pss_pkg::REG_SLIDE_STEP:    slide_step    <= cfg_data[pss_pkg::SLIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the modulus into one to the pattern depth
  logic [MW-1:0] modulus;
  logic [T-1:0]  el;

  always_comb begin
    if (pattern_count == '0) begin
      modulus = MW'(1);
    end else if (32'(pattern_count) > PATTERN_DEPTH) begin
      modulus = MW'(PATTERN_DEPTH);
    end else begin
      modulus = MW'(pattern_count);
    end
  end

  assign el = T'(emitter_life);

  // Global advance: hold everything while a result waits on a stalled receiver
  logic adv;
  logic acc;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // Stage A: offset table access, slide product
  logic [T-1:0]  off_mem [SLOT_DEPTH];
  logic [T-1:0]  off_a;
  logic          keep;
  logic          v_a;
  pss_pkg::ctl_t ctl_a;
  logic [PRW-1:0] prod_a;
  logic [T-1:0]  now_a;
  logic [T-1:0]  ldc_a;
  logic [T-1:0]  ldl_a;
  logic          slot_ok;
  logic          pat_ok;

  assign slot_ok = 32'(entry_index) < SLOT_DEPTH;
  assign pat_ok  = 32'(entry_index) < PATTERN_DEPTH;
  assign keep    = ((op == pss_pkg::OP_EVAL) && slot_ok)
                || ((op == pss_pkg::OP_LOAD_PATTERN) && pat_ok);

  always_ff @(posedge clk) begin
    if (acc && (op == pss_pkg::OP_LOAD_OFFSET) && slot_ok) begin
      off_mem[entry_index[SAW-1:0]] <= T'(offset_value);
    end
    if (acc && (op == pss_pkg::OP_EVAL) && slot_ok) begin
      off_a <= off_mem[entry_index[SAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (adv) begin
      v_a <= acc && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_a.op  <= op;
      ctl_a.idx <= entry_index;
      prod_a    <= PRW'(slide) * PRW'(slide_step);
      now_a     <= T'(frame_time);
      ldc_a     <= T'(pattern_cycle);
      ldl_a     <= T'(pattern_life);
    end
  end

  // Stage B: selection sum and elapsed times
  logic          v_b;
  pss_pkg::ctl_t ctl_b;
  logic [XW-1:0] x_b;
  logic [T-1:0]  now_b;
  logic [T:0]    t_b;
  logic [T:0]    t2_b;
  logic [T-1:0]  ldc_b;
  logic [T-1:0]  ldl_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (adv) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_b <= ctl_a;
      x_b   <= XW'(ctl_a.idx) + XW'(prod_a);
      now_b <= now_a;
      t_b   <= {1'b0, now_a} - {1'b0, off_a};
      t2_b  <= {1'b0, el} - {1'b0, off_a};
      ldc_b <= ldc_a;
      ldl_b <= ldl_a;
    end
  end

  // Pattern selection remainder
  logic          v_m;
  pss_pkg::ctl_t ctl_m;
  logic [MW-1:0] sel_m;
  logic [PW1-1:0] pay_m;
  logic [T-1:0]  now_m;
  logic [T:0]    t_m;
  logic [T:0]    t2_m;
  logic [T-1:0]  ldc_m;
  logic [T-1:0]  ldl_m;

  pss_mod_pipe #(
    .XW (XW),
    .MW (MW),
    .PW (PW1)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (v_b),
    .in_ctl  (ctl_b),
    .in_x    (x_b),
    .in_pay  ({now_b, t_b, t2_b, ldc_b, ldl_b}),
    .modulus (modulus),
    .out_vld (v_m),
    .out_ctl (ctl_m),
    .out_rem (sel_m),
    .out_pay (pay_m)
  );

  assign {now_m, t_m, t2_m, ldc_m, ldl_m} = pay_m;

  // Stage C: pattern table write or read, in item order
  logic [2*T-1:0] pat_mem [PATTERN_DEPTH];
  logic [2*T-1:0] pat_c;
  logic           v_c;
  pss_pkg::ctl_t  ctl_c;
  logic [T-1:0]   now_c;
  logic [T:0]     t_c;
  logic [T:0]     t2_c;

  always_ff @(posedge clk) begin
    if (adv && v_m && (ctl_m.op == pss_pkg::OP_LOAD_PATTERN)) begin
      pat_mem[PAW'(ctl_m.idx)] <= {ldc_m, ldl_m};
    end
    if (adv && v_m && (ctl_m.op == pss_pkg::OP_EVAL)) begin
      pat_c <= pat_mem[sel_m[PAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (adv) begin
      v_c <= v_m && (ctl_m.op == pss_pkg::OP_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_c <= ctl_m;
      now_c <= now_m;
      t_c   <= t_m;
      t2_c  <= t2_m;
    end
  end

  // Magnitudes for the timing divider
  logic [T-1:0] cyc_c;
  logic [T-1:0] life_c;
  logic [T:0]   neg_t;
  logic [T:0]   neg_t2;
  logic [T-1:0] abs_t;
  logic [T-1:0] abs_t2;

  assign cyc_c  = pat_c[2*T-1:T];
  assign life_c = pat_c[T-1:0];
  assign neg_t  = -t_c;
  assign neg_t2 = -t2_c;
  assign abs_t  = t_c[T] ? neg_t[T-1:0] : t_c[T-1:0];
  assign abs_t2 = t2_c[T] ? neg_t2[T-1:0] : t2_c[T-1:0];

  logic          v_d;
  pss_pkg::ctl_t ctl_d;
  logic [T-1:0]  q_d;
  logic [T-1:0]  r_d;
  logic [T-1:0]  r2_d;
  logic [PW2-1:0] pay_d;
  logic [T-1:0]  now_d;
  logic          tneg_d;
  logic          t2neg_d;
  logic [T-1:0]  life_d;
  logic          cycz_d;

  pss_div_pipe #(
    .T  (T),
    .PW (PW2)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (v_c),
    .in_ctl  (ctl_c),
    .num_a   (abs_t),
    .num_b   (abs_t2),
    .den     (cyc_c),
    .in_pay  ({now_c, t_c[T], t2_c[T], life_c, (cyc_c == '0)}),
    .out_vld (v_d),
    .out_ctl (ctl_d),
    .quo_a   (q_d),
    .rem_a   (r_d),
    .rem_b   (r2_d),
    .out_pay (pay_d)
  );

  assign {now_d, tneg_d, t2neg_d, life_d, cycz_d} = pay_d;

  // Final timing and flags
  logic [LW-1:0] qx;
  logic [LW-1:0] loop_v;
  logic [T:0]    start1;
  logic [T:0]    start2;
  logic [T:0]    start_v;
  logic [T+1:0]  end1;
  logic [T+1:0]  end_v;
  logic          exists1;
  logic          late;
  logic          ex_v;
  logic          born_v;

  always_comb begin
    qx      = LW'(q_d);
    loop_v  = tneg_d ? -qx : qx;
    start1  = tneg_d ? ({1'b0, now_d} + {1'b0, r_d}) : ({1'b0, now_d} - {1'b0, r_d});
    start2  = t2neg_d ? ({1'b0, el} + {1'b0, r2_d}) : ({1'b0, el} - {1'b0, r2_d});
    end1    = {1'b0, start1} + (T+2)'(life_d);
    exists1 = end1 > (T+2)'(now_d);
    late    = start1 >= {1'b0, el};
    start_v = start1;
    end_v   = end1;
    ex_v    = exists1;
    born_v  = exists1;
    if (!infinite_mode) begin
      if (late) begin
        start_v = start2;
        end_v   = {1'b0, start2} + (T+2)'(life_d);
        ex_v    = 1'b0;
        born_v  = 1'b0;
      end else begin
        born_v  = 1'b1;
      end
    end
    // negative elapsed time clears both flags
    if (tneg_d) begin
      ex_v   = 1'b0;
      born_v = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot_number <= ctl_d.idx;
      if (cycz_d) begin
        loop_count <= '0;
        start_time <= '0;
        end_time   <= '0;
        exists     <= 1'b0;
        born       <= 1'b0;
      end else begin
        loop_count <= loop_v[pss_pkg::LOOP_W-1:0];
        start_time <= pss_pkg::STAMP_W'(start_v);
        end_time   <= pss_pkg::STAMP_W'(end_v);
        exists     <= ex_v;
        born       <= born_v;
      end
    end
  end

  // Checks
  a_alive_born : assert property (@(posedge clk) disable iff (rst)
    out_valid && exists |-> born)
    else $error("exists without born");

  a_inf_flags : assert property (@(posedge clk) disable iff (rst)
    out_valid && infinite_mode |-> exists == born)
    else $error("flags differ in infinite mode");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

endmodule
